// ===== design/drpd_pkg.sv =====
// Shared widths, constants and register codes of the dual-range presence detector.
package drpd_pkg;

    localparam int HISTORY_DEPTH = 10;

    localparam int US_W       = 16;
    localparam int TS_W       = 32;
    localparam int DIST_W     = 11;
    localparam int REF_W      = 14;
    localparam int LVL_W      = 4;
    localparam int THR_W      = 8;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DIST_MAX = 1114;
    localparam int THR_MAX  = 255;

    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = $clog2(DIST_MAX * HISTORY_DEPTH + 1);
    localparam int CMP_W  = $clog2((DIST_MAX + THR_MAX) * HISTORY_DEPTH + 1);
    localparam int WORD_W = 2 * DIST_W;

    // cm = floor(us * 17 / 1000) as one multiply by a scaled reciprocal
    localparam int CM_MUL_W = 26;
    localparam int CM_SHIFT = 31;
    localparam int PROD_W   = US_W + CM_MUL_W;
    localparam logic [CM_MUL_W-1:0] CM_MUL = 26'd36507228;

    localparam logic [THR_W-1:0]  THR_RST     = 8'd3;
    localparam logic [LVL_W-1:0]  CONFIRM_RST = 4'd3;
    localparam logic [LVL_W-1:0]  LIMIT_RST   = 4'd10;
    localparam logic [HOLD_W-1:0] HOLD_RST    = 16'd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD,
        CFG_CONFIRM,
        CFG_LIMIT,
        CFG_HOLD
    } cfg_index_t;

endpackage

// ===== design/drpd_if.sv =====
// Sample and result channel interfaces of the presence detector.
interface drpd_sample_if import drpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [US_W-1:0]   echo_us_a;
    logic [US_W-1:0]   echo_us_b;
    logic [TS_W-1:0]   now_ms;

    modport source (output valid, echo_us_a, echo_us_b, now_ms, input ready);
    modport sink   (input valid, echo_us_a, echo_us_b, now_ms, output ready);
endinterface

interface drpd_result_if import drpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] dist_a_cm;
    logic [DIST_W-1:0] dist_b_cm;
    logic              raw_hit;
    logic              confirmed;
    logic              present;
    logic              calibrating;
    logic [REF_W-1:0]  ref_sum_a;
    logic [REF_W-1:0]  ref_sum_b;
    logic [LVL_W-1:0]  debounce_level;

    modport source (output valid, dist_a_cm, dist_b_cm, raw_hit, confirmed, present,
                    calibrating, ref_sum_a, ref_sum_b, debounce_level, input ready);
    modport sink   (input valid, dist_a_cm, dist_b_cm, raw_hit, confirmed, present,
                    calibrating, ref_sum_a, ref_sum_b, debounce_level, output ready);
endinterface

// ===== design/dual_range_presence_detector.sv =====
// Top level of the dual-range presence detector.
// Takes one sample word per clock while not stalled and returns one result word per
// sample: one stage converts both echo widths to cm with a constant multiply,
// the next does the read-modify-write of the history ring and updates sums, debounce
// counter and presence, and an output register holds the result. Both history rings sit
// side by side in one synchronous memory; the slot the next word needs is read while the
// current word writes its own slot, so there is no interlock. The first HISTORY_DEPTH
// samples are calibration and only fill the rings and the sums. A stalled result stalls
// the stages behind it, while empty stages keep filling.
module dual_range_presence_detector import drpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    drpd_sample_if.sink           samples,
    drpd_result_if.source         results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [CMP_W-1:0]  DEPTH_C = CMP_W'(HISTORY_DEPTH);
    localparam logic [FILL_W-1:0] FILL_END = FILL_W'(HISTORY_DEPTH);
    localparam logic [PTR_W:0]    PTR_END = (PTR_W + 1)'(HISTORY_DEPTH);

    // configuration
    logic [THR_W-1:0]  thr_reg;
    logic [LVL_W-1:0]  confirm_reg;
    logic [LVL_W-1:0]  limit_reg;
    logic [HOLD_W-1:0] hold_reg;

    // pipeline control
    logic en_out, en_u, en_s1, u_fire;

    // conversion stage
    logic              s1_valid_reg;
    logic [US_W-1:0]   s1_us_a_reg;
    logic [US_W-1:0]   s1_us_b_reg;
    logic [TS_W-1:0]   s1_now_reg;
    logic [PROD_W-1:0] prod_a, prod_b;

    // update stage
    logic              u_valid_reg;
    logic [DIST_W-1:0] u_da_reg;
    logic [DIST_W-1:0] u_db_reg;
    logic [TS_W-1:0]   u_now_reg;
    logic [WORD_W-1:0] rd_data_reg;

    // detector state
    logic [PTR_W-1:0]  ring_pos_reg, ring_pos_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [SUM_W-1:0]  sum_a_reg, sum_a_next;
    logic [SUM_W-1:0]  sum_b_reg, sum_b_next;
    logic [LVL_W-1:0]  hit_cnt_reg, hit_cnt_next;
    logic              present_reg, present_next;
    logic [TS_W-1:0]   start_reg, start_next;

    // ring memory
    logic [WORD_W-1:0] ring_mem [HISTORY_DEPTH];
    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [PTR_W-1:0]  rd_addr;

    // update stage combinational results
    logic              calib, raw_hit, conf, hit_a, hit_b;
    logic [DIST_W-1:0] old_a, old_b;
    logic [CMP_W-1:0]  lim_a, lim_b;
    logic [LVL_W:0]    cnt_inc;
    logic [PTR_W:0]    pos_inc;

    // output register
    logic              out_valid_reg;
    logic [DIST_W-1:0] out_da_reg, out_db_reg;
    logic              out_hit_reg, out_conf_reg, out_present_reg, out_calib_reg;
    logic [REF_W-1:0]  out_sum_a_reg, out_sum_b_reg;
    logic [LVL_W-1:0]  out_level_reg;

    assign en_out = !out_valid_reg || results.ready;
    assign u_fire = u_valid_reg && en_out;
    assign en_u   = !u_valid_reg || en_out;
    assign en_s1  = !s1_valid_reg || en_u;
    assign samples.ready = en_s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= THR_RST;
            confirm_reg <= CONFIRM_RST;
            limit_reg   <= LIMIT_RST;
            hold_reg    <= HOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_THRESHOLD: thr_reg     <= cfg_data[THR_W-1:0];
                CFG_CONFIRM:   confirm_reg <= cfg_data[LVL_W-1:0];
                CFG_LIMIT:     limit_reg   <= cfg_data[LVL_W-1:0];
                CFG_HOLD:      hold_reg    <= cfg_data[HOLD_W-1:0];
                default:       ;
            endcase
        end
    end

    // echo width to cm
    assign prod_a = PROD_W'(s1_us_a_reg) * PROD_W'(CM_MUL);
    assign prod_b = PROD_W'(s1_us_b_reg) * PROD_W'(CM_MUL);

    always_comb
    begin
        calib = fill_reg < FILL_END;
        old_a = rd_data_reg[WORD_W-1:DIST_W];
        old_b = rd_data_reg[DIST_W-1:0];
        // sum - N*d > N*thr  <=>  sum > N*(d + thr)
        lim_a = (CMP_W'(u_da_reg) + CMP_W'(thr_reg)) * DEPTH_C;
        lim_b = (CMP_W'(u_db_reg) + CMP_W'(thr_reg)) * DEPTH_C;
        hit_a = CMP_W'(sum_a_reg) > lim_a;
        hit_b = CMP_W'(sum_b_reg) > lim_b;
        cnt_inc = {1'b0, hit_cnt_reg} + (LVL_W + 1)'(1);
        pos_inc = {1'b0, ring_pos_reg} + (PTR_W + 1)'(1);

        ring_pos_next = ring_pos_reg;
        fill_next     = fill_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        hit_cnt_next  = hit_cnt_reg;
        present_next  = present_reg;
        start_next    = start_reg;
        mem_we        = 1'b0;
        mem_waddr     = ring_pos_reg;
        mem_wdata     = {u_da_reg, u_db_reg};
        raw_hit       = 1'b0;
        conf          = 1'b0;

        if (calib)
        begin
            mem_we     = u_fire;
            mem_waddr  = fill_reg[PTR_W-1:0];
            sum_a_next = sum_a_reg + SUM_W'(u_da_reg);
            sum_b_next = sum_b_reg + SUM_W'(u_db_reg);
            fill_next  = fill_reg + FILL_W'(1);
        end
        else
        begin
            raw_hit = hit_a || hit_b;
            if (raw_hit)
            begin
                if (cnt_inc > {1'b0, limit_reg})
                    hit_cnt_next = limit_reg;
                else
                    hit_cnt_next = cnt_inc[LVL_W-1:0];
            end
            else if (hit_cnt_reg != '0)
            begin
                hit_cnt_next = hit_cnt_reg - LVL_W'(1);
            end
            conf = hit_cnt_next >= confirm_reg;
            if (conf)
            begin
                if (!present_reg)
                begin
                    present_next = 1'b1;
                    start_next   = u_now_reg;
                end
            end
            else
            begin
                // release only after the hold time, wrapping difference
                if (present_reg && ((u_now_reg - start_reg) > TS_W'(hold_reg)))
                    present_next = 1'b0;
                if (!present_next)
                begin
                    mem_we     = u_fire;
                    sum_a_next = sum_a_reg - SUM_W'(old_a) + SUM_W'(u_da_reg);
                    sum_b_next = sum_b_reg - SUM_W'(old_b) + SUM_W'(u_db_reg);
                    ring_pos_next = (pos_inc == PTR_END) ? '0 : pos_inc[PTR_W-1:0];
                end
            end
        end
    end

    // next word reads the slot it will replace while this word writes its own
    assign rd_addr = u_fire ? ring_pos_next : ring_pos_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[mem_waddr] <= mem_wdata;
        if (en_u)
            rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            u_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            ring_pos_reg  <= '0;
            fill_reg      <= '0;
            sum_a_reg     <= '0;
            sum_b_reg     <= '0;
            hit_cnt_reg   <= '0;
            present_reg   <= 1'b0;
            start_reg     <= '0;
        end
        else
        begin
            if (en_s1)
                s1_valid_reg <= samples.valid;
            if (en_u)
                u_valid_reg <= s1_valid_reg;
            if (en_out)
                out_valid_reg <= u_valid_reg;
            if (u_fire)
            begin
                ring_pos_reg <= ring_pos_next;
                fill_reg     <= fill_next;
                sum_a_reg    <= sum_a_next;
                sum_b_reg    <= sum_b_next;
                hit_cnt_reg  <= hit_cnt_next;
                present_reg  <= present_next;
                start_reg    <= start_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_s1 && samples.valid)
        begin
            s1_us_a_reg <= samples.echo_us_a;
            s1_us_b_reg <= samples.echo_us_b;
            s1_now_reg  <= samples.now_ms;
        end
        if (en_u && s1_valid_reg)
        begin
            u_da_reg  <= prod_a[CM_SHIFT +: DIST_W];
            u_db_reg  <= prod_b[CM_SHIFT +: DIST_W];
            u_now_reg <= s1_now_reg;
        end
        if (u_fire)
        begin
            out_da_reg      <= u_da_reg;
            out_db_reg      <= u_db_reg;
            out_hit_reg     <= raw_hit;
            out_conf_reg    <= conf;
            out_present_reg <= present_next;
            out_calib_reg   <= calib;
            out_sum_a_reg   <= REF_W'(sum_a_next);
            out_sum_b_reg   <= REF_W'(sum_b_next);
            out_level_reg   <= hit_cnt_next;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.dist_a_cm      = out_da_reg;
    assign results.dist_b_cm      = out_db_reg;
    assign results.raw_hit        = out_hit_reg;
    assign results.confirmed      = out_conf_reg;
    assign results.present        = out_present_reg;
    assign results.calibrating    = out_calib_reg;
    assign results.ref_sum_a      = out_sum_a_reg;
    assign results.ref_sum_b      = out_sum_b_reg;
    assign results.debounce_level = out_level_reg;

endmodule

// ===== design/drpd_checker.sv =====
// Port-level assertions of the presence detector and their bind.
module drpd_checker import drpd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DIST_W-1:0] dist_a_cm,
    input logic [DIST_W-1:0] dist_b_cm,
    input logic              raw_hit,
    input logic              confirmed,
    input logic              present,
    input logic              calibrating,
    input logic [LVL_W-1:0]  debounce_level
);

    // a waiting result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dist_a_cm) && $stable(dist_b_cm)
            && $stable(present) && $stable(debounce_level))
    else $error("result word changed while stalled");

    // calibration words carry no detection
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && calibrating |-> !raw_hit && !confirmed && !present
            && (debounce_level == '0))
    else $error("detection reported during calibration");

    // confirmation always starts or keeps presence
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && confirmed |-> present)
    else $error("confirmed without presence");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dist_a_cm <= DIST_W'(DIST_MAX)) && (dist_b_cm <= DIST_W'(DIST_MAX)))
    else $error("distance out of range");

endmodule

bind dual_range_presence_detector drpd_checker u_drpd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .dist_a_cm      (results.dist_a_cm),
    .dist_b_cm      (results.dist_b_cm),
    .raw_hit        (results.raw_hit),
    .confirmed      (results.confirmed),
    .present        (results.present),
    .calibrating    (results.calibrating),
    .debounce_level (results.debounce_level)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench of the dual-range presence detector: directed table, random runs.
module tb_top;
    import drpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES      = 10;
    localparam int PHASE_WORDS     = 173;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 2000;

    typedef struct packed {
        logic [US_W-1:0] echo_a;
        logic [US_W-1:0] echo_b;
        logic [TS_W-1:0] now;
    } echo_pair_t;

    typedef struct packed {
        logic [DIST_W-1:0] dist_a;
        logic [DIST_W-1:0] dist_b;
        logic              raw_hit;
        logic              confirmed;
        logic              present;
        logic              calibrating;
        logic [REF_W-1:0]  sum_a;
        logic [REF_W-1:0]  sum_b;
        logic [LVL_W-1:0]  level;
    } detect_word_t;

    // fields of a directed row that are typed in by hand
    typedef struct packed {
        logic              on;
        logic [DIST_W-1:0] dist_a;
        logic [DIST_W-1:0] dist_b;
        logic              calibrating;
    } typed_check_t;

    typedef struct packed {
        logic [US_W-1:0]   echo_a;
        logic [US_W-1:0]   echo_b;
        logic [TS_W-1:0]   now;
        logic [DIST_W-1:0] dist_a;
        logic [DIST_W-1:0] dist_b;
        logic              calibrating;
    } directed_row_t;

    typedef struct packed {
        logic [THR_W-1:0]  thr;
        logic [LVL_W-1:0]  confirm;
        logic [LVL_W-1:0]  limit;
        logic [HOLD_W-1:0] hold;
    } reg_set_t;

    typedef enum {
        ECHO_BACKGROUND,
        ECHO_NEAR_A,
        ECHO_NEAR_B,
        ECHO_NEAR_BOTH,
        ECHO_NOISE
    } echo_kind_e;

    // ten warm-up samples, a confirmed object across the timestamp wrap, its hold and release
    localparam directed_row_t DIRECTED_ROWS [22] = '{
        '{16'd0,     16'd65535, 32'd100,          11'd0,    11'd1114, 1'b1},
        '{16'd65535, 16'd0,     32'd101,          11'd1114, 11'd0,    1'b1},
        '{16'd58,    16'd59,    32'd102,          11'd0,    11'd1,    1'b1},
        '{16'd58823, 16'd58824, 32'd103,          11'd999,  11'd1000, 1'b1},
        '{16'd5900,  16'd11800, 32'd104,          11'd100,  11'd200,  1'b1},
        '{16'd5900,  16'd11800, 32'd105,          11'd100,  11'd200,  1'b1},
        '{16'd5900,  16'd11800, 32'd106,          11'd100,  11'd200,  1'b1},
        '{16'd5900,  16'd11800, 32'd107,          11'd100,  11'd200,  1'b1},
        '{16'd5900,  16'd11800, 32'd108,          11'd100,  11'd200,  1'b1},
        '{16'd5900,  16'd11800, 32'd109,          11'd100,  11'd200,  1'b1},
        '{16'd0,     16'd0,     32'hFFFF_FE00,    11'd0,    11'd0,    1'b0},
        '{16'd0,     16'd0,     32'hFFFF_FE01,    11'd0,    11'd0,    1'b0},
        '{16'd0,     16'd0,     32'hFFFF_FE02,    11'd0,    11'd0,    1'b0},
        '{16'd0,     16'd0,     32'hFFFF_FE03,    11'd0,    11'd0,    1'b0},
        '{16'd65535, 16'd65535, 32'hFFFF_FF00,    11'd1114, 11'd1114, 1'b0},
        '{16'd65535, 16'd65535, 32'h0000_0100,    11'd1114, 11'd1114, 1'b0},
        '{16'd65535, 16'd65535, 32'h0000_05D2,    11'd1114, 11'd1114, 1'b0},
        '{16'd65535, 16'd65535, 32'h0000_05D3,    11'd1114, 11'd1114, 1'b0},
        '{16'd65535, 16'd65535, 32'h0000_05D4,    11'd1114, 11'd1114, 1'b0},
        '{16'd0,     16'd65535, 32'h0000_05E0,    11'd0,    11'd1114, 1'b0},
        '{16'd65535, 16'd0,     32'h0000_05F0,    11'd1114, 11'd0,    1'b0},
        '{16'd40000, 16'd20000, 32'h0000_0600,    11'd680,  11'd340,  1'b0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    drpd_sample_if sample_ch();
    drpd_result_if result_ch();

    dual_range_presence_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // detector copy: configuration, history rings, sums, debounce and presence
    logic [THR_W-1:0]  thr_cfg     = THR_RST;
    logic [LVL_W-1:0]  confirm_cfg = CONFIRM_RST;
    logic [LVL_W-1:0]  limit_cfg   = LIMIT_RST;
    logic [HOLD_W-1:0] hold_cfg    = HOLD_RST;

    logic [DIST_W-1:0] hist_a [HISTORY_DEPTH];
    logic [DIST_W-1:0] hist_b [HISTORY_DEPTH];
    int                next_slot  = 0;
    int                run_sum_a  = 0;
    int                run_sum_b  = 0;
    int                filled     = 0;
    int                level      = 0;
    bit                held       = 1'b0;
    logic [TS_W-1:0]   held_since = '0;

    detect_word_t expected_detections [$];
    typed_check_t typed_now = '0;

    int  mismatches    = 0;
    int  words_checked = 0;
    int  warmups       = 0;
    int  hits_seen     = 0;
    int  starts_seen   = 0;
    int  releases_seen = 0;
    int  quiet_cycles  = 0;
    bit  idle_on       = 1'b1;
    bit  send_calm     = 1'b0;
    bit  hold_off_req  = 1'b0;

    function automatic detect_word_t detect_step(echo_pair_t s);
        detect_word_t    w;
        int              da;
        int              db;
        int              p;
        bit              hit;
        bit              conf;
        bit              cal;
        logic [TS_W-1:0] elapsed;
        da   = int'(s.echo_a) * 17 / 1000;
        db   = int'(s.echo_b) * 17 / 1000;
        hit  = 1'b0;
        conf = 1'b0;
        cal  = 1'b0;
        if (filled < HISTORY_DEPTH) begin
            cal = 1'b1;
            hist_a[filled] = da[DIST_W-1:0];
            hist_b[filled] = db[DIST_W-1:0];
            run_sum_a += da;
            run_sum_b += db;
            filled++;
        end
        else begin
            // reference minus distance above threshold, everything scaled by the depth
            hit = (run_sum_a - HISTORY_DEPTH * da > int'(thr_cfg) * HISTORY_DEPTH) ||
                  (run_sum_b - HISTORY_DEPTH * db > int'(thr_cfg) * HISTORY_DEPTH);
            if (hit) begin
                level++;
                if (level > int'(limit_cfg))
                    level = int'(limit_cfg);
            end
            else if (level > 0) begin
                level--;
            end
            conf = level >= int'(confirm_cfg);
            if (conf) begin
                if (!held) begin
                    held       = 1'b1;
                    held_since = s.now;
                    starts_seen++;
                end
            end
            else begin
                elapsed = s.now - held_since;
                if (held && elapsed > TS_W'(hold_cfg)) begin
                    held = 1'b0;
                    releases_seen++;
                end
                if (!held) begin
                    p = next_slot;
                    run_sum_a = run_sum_a - int'(hist_a[p]) + da;
                    run_sum_b = run_sum_b - int'(hist_b[p]) + db;
                    hist_a[p] = da[DIST_W-1:0];
                    hist_b[p] = db[DIST_W-1:0];
                    next_slot = (p + 1) % HISTORY_DEPTH;
                end
            end
        end
        w.dist_a      = da[DIST_W-1:0];
        w.dist_b      = db[DIST_W-1:0];
        w.raw_hit     = hit;
        w.confirmed   = conf;
        w.present     = held;
        w.calibrating = cal;
        w.sum_a       = run_sum_a[REF_W-1:0];
        w.sum_b       = run_sum_b[REF_W-1:0];
        w.level       = level[LVL_W-1:0];
        return w;
    endfunction

    function automatic string fmt_word(detect_word_t w);
        return $sformatf("dist %0d/%0d hit %0b conf %0b pres %0b cal %0b sums %0d/%0d level %0d",
                         w.dist_a, w.dist_b, w.raw_hit, w.confirmed, w.present,
                         w.calibrating, w.sum_a, w.sum_b, w.level);
    endfunction

    function automatic logic [US_W-1:0] cm_to_us(int cm);
        if (cm < 0)
            cm = 0;
        if (cm > DIST_MAX)
            cm = DIST_MAX;
        return US_W'((cm * 1000 + 16) / 17);
    endfunction

    // both channels sampled at the rising edge
    always @(posedge clk)
    begin
        echo_pair_t   taken;
        detect_word_t want;
        detect_word_t got;
        if (rst_n) begin
            if (sample_ch.valid && sample_ch.ready) begin
                taken = {sample_ch.echo_us_a, sample_ch.echo_us_b, sample_ch.now_ms};
                want  = detect_step(taken);
                if (typed_now.on) begin
                    want.dist_a      = typed_now.dist_a;
                    want.dist_b      = typed_now.dist_b;
                    want.calibrating = typed_now.calibrating;
                end
                warmups   += want.calibrating;
                hits_seen += want.raw_hit;
                expected_detections.push_back(want);
            end
            if (result_ch.valid && result_ch.ready) begin
                got = {result_ch.dist_a_cm, result_ch.dist_b_cm, result_ch.raw_hit,
                       result_ch.confirmed, result_ch.present, result_ch.calibrating,
                       result_ch.ref_sum_a, result_ch.ref_sum_b, result_ch.debounce_level};
                if (expected_detections.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word at %0t: %s", $time, fmt_word(got));
                end
                else begin
                    want = expected_detections.pop_front();
                    if (got.dist_a !== want.dist_a || got.dist_b !== want.dist_b ||
                        got.raw_hit !== want.raw_hit || got.confirmed !== want.confirmed ||
                        got.present !== want.present ||
                        got.calibrating !== want.calibrating ||
                        got.sum_a !== want.sum_a || got.sum_b !== want.sum_b ||
                        got.level !== want.level) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("word %0d mismatch at %0t", words_checked, $time);
                            $display("  expected %s", fmt_word(want));
                            $display("  actual   %s", fmt_word(got));
                        end
                    end
                    words_checked++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d cycles with no word moving", quiet_cycles);
            $display("simulation failed");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side back-pressure
    initial
    begin
        int stall_left;
        bit calm;
        stall_left      = 0;
        calm            = 1'b0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 99) == 0)
                calm = !calm;
            if (stall_left > 0) begin
                stall_left--;
            end
            else if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            else if (idle_on && !calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 18);
            end
            result_ch.ready <= (stall_left == 0);
        end
    end

    // entered and left at a falling edge
    task automatic send_word(input echo_pair_t s, input typed_check_t t);
        if ($urandom_range(0, 40) == 0)
            send_calm = !send_calm;
        if (idle_on && !send_calm && $urandom_range(0, 5) == 0) begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.echo_us_a <= s.echo_a;
        sample_ch.echo_us_b <= s.echo_b;
        sample_ch.now_ms    <= s.now;
        typed_now = t;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (expected_detections.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic program_regs(input reg_set_t rs);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= {8'($urandom_range(0, 255)), rs.thr};
        @(negedge clk);
        cfg_index <= CFG_CONFIRM;
        cfg_data  <= {12'($urandom_range(0, 4095)), rs.confirm};
        @(negedge clk);
        cfg_index <= CFG_LIMIT;
        cfg_data  <= {12'($urandom_range(0, 4095)), rs.limit};
        @(negedge clk);
        cfg_index <= CFG_HOLD;
        cfg_data  <= rs.hold;
        @(negedge clk);
        cfg_we      <= 1'b0;
        thr_cfg     = rs.thr;
        confirm_cfg = rs.confirm;
        limit_cfg   = rs.limit;
        hold_cfg    = rs.hold;
    endtask

    initial
    begin
        reg_set_t        plan [NUM_PHASES];
        echo_kind_e      kind;
        echo_pair_t      s;
        logic [TS_W-1:0] now_ms;
        int              run_left;
        int              bg_a;
        int              bg_b;
        int              cm_a;
        int              cm_b;
        int              thr;
        int              r;
        bit              near_a;
        bit              near_b;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_THRESHOLD;
        cfg_data            = '0;
        sample_ch.valid     = 1'b0;
        sample_ch.echo_us_a = '0;
        sample_ch.echo_us_b = '0;
        sample_ch.now_ms    = '0;

        plan[0] = '{8'd3,   4'd3,  4'd10, 16'd2000};
        plan[1] = '{8'd0,   4'd1,  4'd1,  16'd0};
        plan[2] = '{8'd255, 4'd15, 4'd15, 16'd65535};
        plan[3] = '{8'd10,  4'd0,  4'd5,  16'd100};
        plan[4] = '{8'd5,   4'd4,  4'd0,  16'd50};
        plan[5] = '{8'd20,  4'd15, 4'd15, 16'd500};
        plan[6] = '{8'd8,   4'd2,  4'd3,  16'd1000};
        plan[7] = '{8'd1,   4'd5,  4'd8,  16'd65535};
        for (int i = 8; i < NUM_PHASES; i++)
            plan[i] = '{8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                        4'($urandom_range(0, 15)), 16'($urandom_range(0, 3000))};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset register values are still in force here
        foreach (DIRECTED_ROWS[i])
            send_word({DIRECTED_ROWS[i].echo_a, DIRECTED_ROWS[i].echo_b, DIRECTED_ROWS[i].now},
                      {1'b1, DIRECTED_ROWS[i].dist_a, DIRECTED_ROWS[i].dist_b,
                       DIRECTED_ROWS[i].calibrating});

        run_left = 0;
        kind     = ECHO_BACKGROUND;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            program_regs(plan[ph]);
            if (ph == NUM_PHASES - 1)
                idle_on = 1'b0;
            if (ph == 2)
                hold_off_req = 1'b1;
            thr    = int'(plan[ph].thr);
            bg_a   = $urandom_range(20, 1100);
            bg_b   = $urandom_range(20, 1100);
            now_ms = (ph % 3 == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom();
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (run_left == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 45)
                        kind = ECHO_BACKGROUND;
                    else if (r < 60)
                        kind = ECHO_NEAR_A;
                    else if (r < 70)
                        kind = ECHO_NEAR_B;
                    else if (r < 88)
                        kind = ECHO_NEAR_BOTH;
                    else
                        kind = ECHO_NOISE;
                    run_left = (kind == ECHO_NOISE)      ? $urandom_range(1, 3) :
                               (kind == ECHO_BACKGROUND) ? $urandom_range(1, 20) :
                                                           $urandom_range(1, 16);
                end
                run_left--;

                r = $urandom_range(0, 99);
                if (r == 0)
                    now_ms = $urandom();
                else if (r < 6)
                    now_ms += $urandom_range(0, 2 * int'(plan[ph].hold) + 10);
                else
                    now_ms += $urandom_range(0, 30);

                near_a = (kind == ECHO_NEAR_A || kind == ECHO_NEAR_BOTH);
                near_b = (kind == ECHO_NEAR_B || kind == ECHO_NEAR_BOTH);
                // an object sits clearly inside the threshold, or now and then right on it
                if ($urandom_range(0, 3) == 0) begin
                    cm_a = near_a ? bg_a - thr - 2 + int'($urandom_range(0, 3)) : bg_a;
                    cm_b = near_b ? bg_b - thr - 2 + int'($urandom_range(0, 3)) : bg_b;
                end
                else begin
                    cm_a = near_a ? bg_a - thr - 1 - int'($urandom_range(0, 30))
                                  : bg_a - 1 + int'($urandom_range(0, 2));
                    cm_b = near_b ? bg_b - thr - 1 - int'($urandom_range(0, 30))
                                  : bg_b - 1 + int'($urandom_range(0, 2));
                end
                s.now = now_ms;
                if (kind == ECHO_NOISE) begin
                    s.echo_a = $urandom_range(0, 65535);
                    s.echo_b = $urandom_range(0, 65535);
                end
                else begin
                    s.echo_a = cm_to_us(cm_a);
                    s.echo_b = cm_to_us(cm_b);
                end
                send_word(s, '0);
            end
        end

        drain();
        repeat (8) @(posedge clk);

        $display("%0d words checked over %0d register settings, %0d of them warm-up samples",
                 words_checked, NUM_PHASES + 1, warmups);
        $display("%0d raw hits, %0d presence starts, %0d releases, %0d mismatches",
                 hits_seen, starts_seen, releases_seen, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
